>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, held off while reset is high.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

>>> hw/rtl/nfa_pkg.sv
`timescale 1ns / 1ps
package nfa_pkg;
   localparam int MAX_STATES_DEF = 32;
   localparam int IDX_W = 5;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [1:0] TY_SINGLE = 2'd0;
   localparam logic [1:0] TY_SPLIT  = 2'd1;
   localparam logic [1:0] TY_MATCH  = 2'd2;

   typedef struct packed {
      logic write_entry;  // store the request word into the table
      logic latch_byte;   // hold text byte for the step
      logic round;        // one epsilon propagation round
      logic step;         // byte transition, folding in the closure match
      logic finish;       // emit result word
      logic done;         // result is for an end of string
      logic rearm;        // reload start state, clear flag
   } nfa_cmd_type;

   typedef struct packed {
      logic stable;       // closure round adds nothing
      logic out_free;     // result register can take a word
   } nfa_stat_type;
endpackage

>>> hw/rtl/nfa_datapath.sv
`timescale 1ns / 1ps
module nfa_datapath import nfa_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  nfa_cmd_type       cmd,
   output nfa_stat_type      stat,
   input  logic [IDX_W-1:0]  entry_index,
   input  logic [1:0]        entry_type,
   input  logic [7:0]        entry_byte,
   input  logic              entry_any,
   input  logic [IDX_W-1:0]  entry_next,
   input  logic [IDX_W-1:0]  entry_alt,
   input  logic [7:0]        text_byte,
   input  logic              csr_write,
   input  logic [IDX_W-1:0]  csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_matched,
   output logic              rsp_string_done
);
   function automatic logic [MAX_STATES-1:0] bit_of(input logic [IDX_W-1:0] idx);
      logic [MAX_STATES-1:0] res;
      res = '0;
      for (int j = 0; j < MAX_STATES; j++) res[j] = (int'(idx) == j);
      return res;
   endfunction

   logic [1:0]       type_ff [MAX_STATES];
   logic [7:0]       byte_ff [MAX_STATES];
   logic             any_ff  [MAX_STATES];
   logic [IDX_W-1:0] next_ff [MAX_STATES];
   logic [IDX_W-1:0] alt_ff  [MAX_STATES];

   logic [MAX_STATES-1:0] set_ff, set_in;
   logic [IDX_W-1:0]      start_ff;
   logic                  match_ff, match_in;
   logic [7:0]            char_ff;
   logic                  rsp_valid_ff, rsp_matched_ff, rsp_done_ff;

   logic [MAX_STATES-1:0] grown, stepped;
   logic                  hold_match;

   always_comb begin
      grown = set_ff;
      stepped = '0;
      hold_match = 1'b0;
      for (int i = 0; i < MAX_STATES; i++) begin
         if (set_ff[i] && type_ff[i] == TY_SPLIT)
            grown = grown | bit_of(next_ff[i]) | bit_of(alt_ff[i]);
         if (set_ff[i] && type_ff[i] == TY_SINGLE && (any_ff[i] || byte_ff[i] == char_ff))
            stepped = stepped | bit_of(next_ff[i]);
         if (set_ff[i] && type_ff[i] == TY_MATCH)
            hold_match = 1'b1;
      end
   end

   assign stat.stable   = (grown == set_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      set_in = set_ff;
      match_in = match_ff;
      if (cmd.round) set_in = grown;
      if (cmd.step) begin
         set_in = stepped;
         match_in = match_ff | hold_match;
      end
      if (cmd.finish) match_in = match_ff | hold_match;
      if (cmd.rearm) begin
         set_in = bit_of(start_ff);
         match_in = 1'b0;
      end
      if (csr_write) begin
         set_in = bit_of(csr_wdata);
         match_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_STATES; j++) begin
         if (cmd.write_entry && int'(entry_index) == j) begin
            type_ff[j] <= entry_type;
            byte_ff[j] <= entry_byte;
            any_ff[j]  <= entry_any;
            next_ff[j] <= entry_next;
            alt_ff[j]  <= entry_alt;
         end
      end
      if (cmd.latch_byte) char_ff <= text_byte;
      if (cmd.finish) begin
         rsp_matched_ff <= match_ff | hold_match;
         rsp_done_ff    <= cmd.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff <= bit_of('0);
         start_ff <= '0;
         match_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         set_ff <= set_in;
         match_ff <= match_in;
         if (csr_write) start_ff <= csr_wdata;
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_string_done = rsp_done_ff;
endmodule

>>> hw/rtl/nfa_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nfa_ctrl import nfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_kind,
   input  nfa_stat_type stat,
   output nfa_cmd_type  cmd
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CLOSE1 = 2'd1;
   localparam logic [1:0] S_CLOSE2 = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       end_ff, end_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      end_in = end_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: cmd.write_entry = 1'b1;
                  KIND_BYTE: begin
                     cmd.latch_byte = 1'b1;
                     end_in = 1'b0;
                     state_in = S_CLOSE1;
                  end
                  KIND_END: begin
                     end_in = 1'b1;
                     state_in = S_CLOSE1;
                  end
                  default: ;
               endcase
            end
         end
         S_CLOSE1: begin
            if (!stat.stable) cmd.round = 1'b1;
            else if (!end_ff) begin
               cmd.step = 1'b1;
               state_in = S_CLOSE2;
            end else if (stat.out_free) begin
               cmd.finish = 1'b1;
               cmd.done = 1'b1;
               cmd.rearm = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLOSE2: begin
            if (!stat.stable) cmd.round = 1'b1;
            else if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         end_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff <= end_in;
      end
   end

   `ASSERT_CLK(a_finish_needs_stable, clock, reset, cmd.finish |-> stat.stable && stat.out_free)
   `ASSERT_CLK(a_step_only_byte, clock, reset, cmd.step |-> !end_ff && state_ff == S_CLOSE1)
   `ASSERT_CLK(a_busy_after_text, clock, reset, accept && req_kind == KIND_BYTE |=> !req_ready)
   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> state_ff == S_IDLE)
endmodule

>>> hw/rtl/nfa_regex_matcher_core.sv
`timescale 1ns / 1ps
// Thompson NFA matcher. Load words fill a MAX_STATES-slot (default 32) state
// table (single, split or match entries); text words advance the active
// state set; an end word returns the sticky match flag with string_done set
// and re-arms the set to start_state. Loads give no result. A text word runs
// closure rounds, the byte step, then closure rounds again; an end word runs
// closure rounds only; rounds (at most MAX_STATES each) run one per cycle
// on the single shared propagation unit. Writing start_state also re-arms.
module nfa_regex_matcher_core import nfa_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic [IDX_W-1:0] req_entry_index,
   input  logic [1:0]       req_entry_type,
   input  logic [7:0]       req_entry_byte,
   input  logic             req_entry_any,
   input  logic [IDX_W-1:0] req_entry_next,
   input  logic [IDX_W-1:0] req_entry_alt,
   input  logic [7:0]       req_text_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_matched,
   output logic             rsp_string_done,
   input  logic             csr_write,
   input  logic [IDX_W-1:0] csr_wdata
);
   nfa_cmd_type  cmd;
   nfa_stat_type stat;

   // Sequencer: accepts words, runs closure rounds until the set settles.
   nfa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .stat(stat), .cmd(cmd)
   );

   // Table, active set, match flag and result register.
   nfa_datapath #(.MAX_STATES(MAX_STATES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .entry_index(req_entry_index), .entry_type(req_entry_type),
      .entry_byte(req_entry_byte), .entry_any(req_entry_any),
      .entry_next(req_entry_next), .entry_alt(req_entry_alt),
      .text_byte(req_text_byte),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_matched(rsp_matched), .rsp_string_done(rsp_string_done)
   );
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import nfa_pkg::*;

   localparam logic [1:0] KIND_NOISE = 2'd3;  // ignored by the core
   localparam logic [1:0] TY_DEAD    = 2'd3;  // no successors, no match
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 150;          // extra wait after the queue drains

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] index;
      logic [1:0] ety;
      logic [7:0] ebyte;
      logic       eany;
      logic [4:0] enext;
      logic [4:0] ealt;
      logic [7:0] tbyte;
   } word_type;

   typedef struct packed {
      logic matched;
      logic done;
   } flag_type;

   // Predicts the match flag of the NFA and checks response words.
   class match_scoreboard;
      logic [1:0]  ty [32];
      logic [7:0]  byt [32];
      logic        any [32];
      logic [4:0]  nx [32];
      logic [4:0]  alt [32];
      logic [31:0] active;
      logic [4:0]  start;
      logic        seen;
      flag_type    expected_flags[$];
      int          mismatches;

      function void set_start(logic [4:0] s);
         start  = s;
         active = 32'b1 << s;
         seen   = 1'b0;
      endfunction

      function logic [31:0] closure(logic [31:0] s);
         logic [31:0] grown;
         for (int r = 0; r < 32; r++) begin
            grown = s;
            for (int i = 0; i < 32; i++)
               if (s[i] && ty[i] == TY_SPLIT) begin
                  grown[nx[i]]  = 1'b1;
                  grown[alt[i]] = 1'b1;
               end
            if (grown == s) break;
            s = grown;
         end
         return s;
      endfunction

      function logic has_match(logic [31:0] s);
         for (int i = 0; i < 32; i++)
            if (s[i] && ty[i] == TY_MATCH) return 1'b1;
         return 1'b0;
      endfunction

      function void note_word(word_type w);
         logic [31:0] cur, nxt;
         case (w.kind)
            KIND_LOAD: begin
               ty[w.index]  = w.ety;
               byt[w.index] = w.ebyte;
               any[w.index] = w.eany;
               nx[w.index]  = w.enext;
               alt[w.index] = w.ealt;
            end
            KIND_BYTE: begin
               cur = closure(active);
               nxt = '0;
               if (has_match(cur)) seen = 1'b1;
               for (int i = 0; i < 32; i++)
                  if (cur[i] && ty[i] == TY_SINGLE && (any[i] || byt[i] == w.tbyte))
                     nxt[nx[i]] = 1'b1;
               nxt = closure(nxt);
               if (has_match(nxt)) seen = 1'b1;
               active = nxt;
               expected_flags.push_back('{seen, 1'b0});
            end
            KIND_END: begin
               if (has_match(closure(active))) seen = 1'b1;
               expected_flags.push_back('{seen, 1'b1});
               active = 32'b1 << start;
               seen   = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic m, logic d);
         flag_type e;
         if (expected_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word matched=%0d done=%0d", m, d);
            return;
         end
         e = expected_flags.pop_front();
         if (e.matched !== m || e.done !== d) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: exp matched=%0d done=%0d, got matched=%0d done=%0d",
                        e.matched, e.done, m, d);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   word_type   req_word = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_matched, rsp_string_done;
   logic       csr_write = 1'b0;
   logic [4:0] csr_wdata = '0;

   match_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int stall_cycles  = 0;
   string demo_text  = "abcbd";

   nfa_regex_matcher_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_word.kind),
      .req_entry_index (req_word.index),
      .req_entry_type  (req_word.ety),
      .req_entry_byte  (req_word.ebyte),
      .req_entry_any   (req_word.eany),
      .req_entry_next  (req_word.enext),
      .req_entry_alt   (req_word.ealt),
      .req_text_byte   (req_word.tbyte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_matched     (rsp_matched),
      .rsp_string_done (rsp_string_done),
      .csr_write       (csr_write),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Response side: check accepted words, then pick next ready.
   // A hold-off request keeps ready low for a counted stretch.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_matched, rsp_string_done);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: cycles with no handshake on either channel.
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("testbench failed");
      $finish;
   end

   // Offer one word; random gaps first, then hold until accepted.
   task automatic send_word(word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_word(w);
   endtask

   task automatic drain();
      while (sb.expected_flags.size() != 0) @(posedge clock);
   endtask

   // Start state writes only when nothing is in flight.
   task automatic write_start(logic [4:0] s);
      req_valid <= 1'b0;
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= s;
      sb.set_start(s);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Random fill keeps unused fields toggling.
   function automatic word_type noise_fields();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[$bits(word_type)-1:0];
   endfunction

   function automatic word_type load_word(int idx, logic [1:0] t, logic [7:0] b, logic a,
                                          int n, int al);
      word_type w;
      w       = noise_fields();
      w.kind  = KIND_LOAD;
      w.index = 5'(idx);
      w.ety   = t;
      w.ebyte = b;
      w.eany  = a;
      w.enext = 5'(n);
      w.ealt  = 5'(al);
      return w;
   endfunction

   function automatic word_type text_word(logic [7:0] c);
      word_type w;
      w       = noise_fields();
      w.kind  = KIND_BYTE;
      w.tbyte = c;
      return w;
   endfunction

   function automatic word_type end_word();
      word_type w;
      w      = noise_fields();
      w.kind = KIND_END;
      return w;
   endfunction

   // Mostly small alphabet so strings actually walk the NFA.
   function automatic logic [7:0] pick_char();
      if ($urandom_range(99) < 85) return 8'(8'h61 + $urandom_range(3));
      return 8'($urandom_range(255));
   endfunction

   function automatic word_type random_entry(int idx);
      int p;
      logic [1:0] t;
      p = $urandom_range(99);
      if (p < 50) t = TY_SINGLE;
      else if (p < 82) t = TY_SPLIT;
      else if (p < 94) t = TY_MATCH;
      else t = TY_DEAD;
      return load_word(idx, t, pick_char(), ($urandom_range(99) < 15),
                       $urandom_range(31), $urandom_range(31));
   endfunction

   int sent;

   task automatic random_phase(int count);
      int len;
      while (sent < count) begin
         if ($urandom_range(99) < 8) begin
            for (int i = 0; i < 32; i++) send_word(random_entry(i));
            sent += 32;
         end
         len = $urandom_range(10);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 3) begin
               send_word(random_entry($urandom_range(31)));
               sent++;
            end else if ($urandom_range(99) < 3) begin
               word_type w;
               w      = noise_fields();
               w.kind = KIND_NOISE;
               send_word(w);
               sent++;
            end
            send_word(text_word(pick_char()));
            sent++;
         end
         send_word(end_word());
         sent++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_start(5'd0);

      // Every slot defined before any text word; dead entries, all-ones fields.
      for (int i = 0; i < 32; i++) send_word(load_word(i, TY_DEAD, 8'hff, 1'b1, 31, 31));
      // a(b|c)*d, match at slot 7
      send_word(load_word(0, TY_SINGLE, 8'h61, 1'b0, 1, 0));
      send_word(load_word(1, TY_SPLIT,  8'h00, 1'b0, 2, 4));
      send_word(load_word(2, TY_SPLIT,  8'h00, 1'b0, 5, 6));
      send_word(load_word(5, TY_SINGLE, 8'h62, 1'b0, 1, 0));
      send_word(load_word(6, TY_SINGLE, 8'h63, 1'b0, 1, 0));
      send_word(load_word(4, TY_SINGLE, 8'h64, 1'b0, 7, 0));
      send_word(load_word(7, TY_MATCH,  8'h00, 1'b0, 0, 0));
      send_word(load_word(30, TY_SINGLE, 8'h00, 1'b0, 31, 0));
      send_word(load_word(31, TY_MATCH, 8'hff, 1'b1, 31, 31));

      for (int i = 0; i < demo_text.len(); i++) send_word(text_word(demo_text[i]));
      send_word(text_word(8'h00));    // bytes keep flowing after a match
      send_word(end_word());
      send_word(end_word());          // empty string, start not accepting
      send_word(text_word(8'hff));
      send_word(end_word());
      begin
         word_type w;
         w      = noise_fields();
         w.kind = KIND_NOISE;
         send_word(w);
      end
      write_start(5'd7);              // start on match: empty string accepted
      send_word(end_word());
      write_start(5'd30);
      send_word(text_word(8'h00));
      send_word(end_word());
      write_start(5'd31);
      send_word(text_word(8'hff));
      send_word(end_word());

      // Phase 1: sender idles little, receiver a lot, plus a long hold-off.
      write_start(5'($urandom_range(31)));
      send_idle_pct = 22;
      recv_idle_pct = 75;
      hold_request  = 400;
      sent = 0;
      random_phase(600);

      // Phase 2: roles swapped, with a full drain mid-way.
      write_start(5'd0);
      send_idle_pct = 75;
      recv_idle_pct = 22;
      random_phase(900);
      req_valid <= 1'b0;
      drain();
      random_phase(1200);

      // Phase 3: back to back.
      write_start(5'd31);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(1800);

      req_valid <= 1'b0;
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_flags.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
